FILE: sv/debounced_toggle_relay_controller_defines.svh
// ----------------------------------------------------------------------------
// Debounced toggle relay controller: assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_TOGGLE_RELAY_CONTROLLER_DEFINES_SVH
`define DEBOUNCED_TOGGLE_RELAY_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DTRC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DTRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/dtrc_pkg.sv
// ----------------------------------------------------------------------------
// Debounced toggle relay controller: package
// Phase codes, register map, and the configuration and result bundles.
// ----------------------------------------------------------------------------
package dtrc_pkg;

  localparam int unsigned TICK_W   = 16;
  localparam int unsigned BLINK_W  = 5;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 5;

  localparam logic [TICK_W-1:0]  DEBOUNCE_RST   = 16'd150;
  localparam logic [TICK_W-1:0]  LED_GAP_RST    = 16'd781;
  localparam logic [TICK_W-1:0]  LOCKOUT_RST    = 16'd3906;
  localparam logic [TICK_W-1:0]  BLINK_HALF_RST = 16'd781;
  localparam logic [BLINK_W-1:0] BLINK_TOG_RST  = 5'd10;

  typedef enum logic [2:0] {
    PH_PWR_GAP     = 3'd0,
    PH_PWR_RELEASE = 3'd1,
    PH_BLINK       = 3'd2,
    PH_RELEASE     = 3'd3,
    PH_SLEEP       = 3'd4,
    PH_CHECK       = 3'd5,
    PH_GAP         = 3'd6,
    PH_LOCKOUT     = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_LED_GAP    = 3'd1,
    REG_LOCKOUT    = 3'd2,
    REG_BLINK_HALF = 3'd3,
    REG_BLINK_TOG  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [TICK_W-1:0]  debounce_ticks;
    logic [TICK_W-1:0]  led_gap_ticks;
    logic [TICK_W-1:0]  lockout_ticks;
    logic [TICK_W-1:0]  blink_half_ticks;
    logic [BLINK_W-1:0] blink_toggles;
  } cfg_t;

  typedef struct packed {
    logic relay_on;
    logic led_closed;
    logic led_open;
    logic sleeping;
  } result_t;

endpackage

FILE: sv/dtrc_core.sv
// ----------------------------------------------------------------------------
// Debounced toggle relay controller: sequencer core
// Holds the phase, tick counter and LED/relay state; computes one tick's
// update and the resulting outputs from the current sample.
// ----------------------------------------------------------------------------
module dtrc_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               level,
  input  dtrc_pkg::cfg_t     cfg,
  output dtrc_pkg::result_t  result
);

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned CMP_W = (CW > dtrc_pkg::TICK_W) ? CW : dtrc_pkg::TICK_W;

  dtrc_pkg::phase_t phase, phase_next;
  logic [CW-1:0] tick_count, tick_count_next;
  logic          last_level, last_level_next;
  logic          toggled_on, toggled_on_next;
  logic [dtrc_pkg::BLINK_W-1:0] blink_count, blink_count_next;
  logic          relay_reg, relay_reg_next;
  logic          led_closed_reg, led_closed_reg_next;
  logic          led_open_reg, led_open_reg_next;

  logic [CW-1:0] cnt_up, rel_cnt, chk_cnt;
  logic [dtrc_pkg::BLINK_W-1:0] blink_inc;
  logic rel_done, chk_done, gap_done, lock_done, half_done;

  // a saturated counter has reached any limit, clipped or not
  function automatic logic reached(input logic [CW-1:0] cnt,
                                   input logic [dtrc_pkg::TICK_W-1:0] lim);
    logic [CMP_W-1:0] c;
    logic [CMP_W-1:0] l;
    c = CMP_W'(cnt);
    l = CMP_W'(lim);
    return (&cnt) || (c >= l);
  endfunction

  function automatic logic [dtrc_pkg::TICK_W-1:0] at_least_one(
      input logic [dtrc_pkg::TICK_W-1:0] lim);
    return (lim == '0) ? dtrc_pkg::TICK_W'(1) : lim;
  endfunction

  assign cnt_up    = (&tick_count) ? tick_count : tick_count + CW'(1);
  assign rel_cnt   = level ? cnt_up : '0;
  assign chk_cnt   = (level == last_level) ? cnt_up : '0;
  assign blink_inc = blink_count + dtrc_pkg::BLINK_W'(1);

  assign rel_done  = reached(rel_cnt, cfg.debounce_ticks);
  assign chk_done  = reached(chk_cnt, cfg.debounce_ticks);
  assign gap_done  = reached(cnt_up, at_least_one(cfg.led_gap_ticks));
  assign lock_done = reached(cnt_up, at_least_one(cfg.lockout_ticks));
  assign half_done = reached(cnt_up, at_least_one(cfg.blink_half_ticks));

  always_comb begin
    phase_next = phase;
    unique case (phase)
      dtrc_pkg::PH_PWR_GAP: begin
        if (gap_done) phase_next = dtrc_pkg::PH_PWR_RELEASE;
      end
      dtrc_pkg::PH_PWR_RELEASE: begin
        if (rel_done) begin
          phase_next = (cfg.blink_toggles == '0) ? dtrc_pkg::PH_RELEASE
                                                 : dtrc_pkg::PH_BLINK;
        end
      end
      dtrc_pkg::PH_BLINK: begin
        if (half_done && (blink_inc >= cfg.blink_toggles)) phase_next = dtrc_pkg::PH_RELEASE;
      end
      dtrc_pkg::PH_RELEASE: begin
        if (rel_done) phase_next = dtrc_pkg::PH_SLEEP;
      end
      dtrc_pkg::PH_SLEEP: begin
        if (!level) phase_next = dtrc_pkg::PH_CHECK;
      end
      dtrc_pkg::PH_CHECK: begin
        // the held level is always the current sample after this tick
        if (chk_done) phase_next = level ? dtrc_pkg::PH_RELEASE : dtrc_pkg::PH_GAP;
      end
      dtrc_pkg::PH_GAP: begin
        if (gap_done) phase_next = dtrc_pkg::PH_LOCKOUT;
      end
      dtrc_pkg::PH_LOCKOUT: begin
        if (lock_done) phase_next = dtrc_pkg::PH_RELEASE;
      end
    endcase
  end

  always_comb begin
    tick_count_next     = tick_count;
    last_level_next     = last_level;
    toggled_on_next     = toggled_on;
    blink_count_next    = blink_count;
    relay_reg_next      = relay_reg;
    led_closed_reg_next = led_closed_reg;
    led_open_reg_next   = led_open_reg;
    unique case (phase)
      dtrc_pkg::PH_PWR_GAP: begin
        tick_count_next = cnt_up;
        if (gap_done) begin
          led_open_reg_next = 1'b0;
          tick_count_next   = '0;
        end
      end
      dtrc_pkg::PH_PWR_RELEASE: begin
        tick_count_next = rel_cnt;
        if (rel_done) begin
          tick_count_next  = '0;
          blink_count_next = '0;
        end
      end
      dtrc_pkg::PH_BLINK: begin
        tick_count_next = cnt_up;
        if (half_done) begin
          led_closed_reg_next = ~led_closed_reg;
          led_open_reg_next   = ~led_open_reg;
          blink_count_next    = blink_inc;
          tick_count_next     = '0;
        end
      end
      dtrc_pkg::PH_RELEASE: begin
        tick_count_next = rel_done ? '0 : rel_cnt;
      end
      dtrc_pkg::PH_SLEEP: begin
        if (!level) begin
          last_level_next = 1'b0;
          tick_count_next = '0;
        end
      end
      dtrc_pkg::PH_CHECK: begin
        last_level_next = level;
        tick_count_next = chk_cnt;
        if (chk_done) begin
          tick_count_next = '0;
          if (!level) begin
            toggled_on_next = ~toggled_on;
            // drive relay and the new LED now; the old LED clears after the gap
            if (!toggled_on) begin
              relay_reg_next    = 1'b1;
              led_open_reg_next = 1'b1;
            end else begin
              relay_reg_next      = 1'b0;
              led_closed_reg_next = 1'b1;
            end
          end
        end
      end
      dtrc_pkg::PH_GAP: begin
        tick_count_next = cnt_up;
        if (gap_done) begin
          if (toggled_on) led_closed_reg_next = 1'b0;
          else            led_open_reg_next   = 1'b0;
          tick_count_next = '0;
        end
      end
      dtrc_pkg::PH_LOCKOUT: begin
        tick_count_next = lock_done ? '0 : cnt_up;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= dtrc_pkg::PH_PWR_GAP;
      tick_count     <= '0;
      last_level     <= 1'b1;
      toggled_on     <= 1'b0;
      blink_count    <= '0;
      relay_reg      <= 1'b0;
      led_closed_reg <= 1'b1;
      led_open_reg   <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      last_level     <= last_level_next;
      toggled_on     <= toggled_on_next;
      blink_count    <= blink_count_next;
      relay_reg      <= relay_reg_next;
      led_closed_reg <= led_closed_reg_next;
      led_open_reg   <= led_open_reg_next;
    end
  end

  assign result.relay_on   = relay_reg_next;
  assign result.led_closed = led_closed_reg_next;
  assign result.led_open   = led_open_reg_next;
  assign result.sleeping   = (phase_next == dtrc_pkg::PH_SLEEP);

endmodule

FILE: sv/debounced_toggle_relay_controller.sv
// ----------------------------------------------------------------------------
// Debounced toggle relay controller
// One switch sample (active low) is taken per transaction, one per clock at
// full rate; the relay, LED and sleep outputs after that tick come out as one
// result transaction from the output register. A new sample is
// taken only while that register is empty or is drained in the same cycle, so
// a result left waiting stalls the input. The phase, tick counter and LED
// state advance at the same edge the sample is accepted, so a sustained rate
// of one sample per cycle is set by that single update step. The user writes
// timing registers over the APB port at byte address 4*index only while the
// block is idle (unenforced); the COUNT_WIDTH-bit tick counter saturates.
// ----------------------------------------------------------------------------
`include "debounced_toggle_relay_controller_defines.svh"

module debounced_toggle_relay_controller #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        switch_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        relay_on,
  output logic                        led_closed,
  output logic                        led_open,
  output logic                        sleeping,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dtrc_pkg::APB_AW-1:0] paddr,
  input  logic [dtrc_pkg::APB_DW-1:0] pwdata,
  output logic [dtrc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  dtrc_pkg::cfg_t    cfg;
  dtrc_pkg::result_t result;
  dtrc_pkg::reg_idx_t reg_idx;
  logic in_accept;
  logic cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = dtrc_pkg::reg_idx_t'(paddr[dtrc_pkg::APB_AW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= dtrc_pkg::DEBOUNCE_RST;
      cfg.led_gap_ticks    <= dtrc_pkg::LED_GAP_RST;
      cfg.lockout_ticks    <= dtrc_pkg::LOCKOUT_RST;
      cfg.blink_half_ticks <= dtrc_pkg::BLINK_HALF_RST;
      cfg.blink_toggles    <= dtrc_pkg::BLINK_TOG_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        dtrc_pkg::REG_DEBOUNCE:   cfg.debounce_ticks   <= pwdata[dtrc_pkg::TICK_W-1:0];
        dtrc_pkg::REG_LED_GAP:    cfg.led_gap_ticks    <= pwdata[dtrc_pkg::TICK_W-1:0];
        dtrc_pkg::REG_LOCKOUT:    cfg.lockout_ticks    <= pwdata[dtrc_pkg::TICK_W-1:0];
        dtrc_pkg::REG_BLINK_HALF: cfg.blink_half_ticks <= pwdata[dtrc_pkg::TICK_W-1:0];
        dtrc_pkg::REG_BLINK_TOG:  cfg.blink_toggles    <= pwdata[dtrc_pkg::BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dtrc_pkg::REG_DEBOUNCE:   prdata = dtrc_pkg::APB_DW'(cfg.debounce_ticks);
      dtrc_pkg::REG_LED_GAP:    prdata = dtrc_pkg::APB_DW'(cfg.led_gap_ticks);
      dtrc_pkg::REG_LOCKOUT:    prdata = dtrc_pkg::APB_DW'(cfg.lockout_ticks);
      dtrc_pkg::REG_BLINK_HALF: prdata = dtrc_pkg::APB_DW'(cfg.blink_half_ticks);
      dtrc_pkg::REG_BLINK_TOG:  prdata = dtrc_pkg::APB_DW'(cfg.blink_toggles);
      default:                  prdata = '0;
    endcase
  end

  // take a sample whenever the output register is empty or being drained
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  dtrc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (in_accept),
    .level  (switch_level),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      relay_on   <= result.relay_on;
      led_closed <= result.led_closed;
      led_open   <= result.led_open;
      sleeping   <= result.sleeping;
    end
  end

  `DTRC_ASSERT_SAME(a_drain_frees_input, clk, rst, out_ready, in_ready,
                    "input stalled while output drains")
  `DTRC_ASSERT_NEXT(a_accept_gives_result, clk, rst, in_accept, out_valid,
                    "accepted sample gave no result")
  `DTRC_ASSERT_SAME(a_sleep_relay_leds, clk, rst, out_valid && sleeping && relay_on,
                    led_open && !led_closed, "relay on in sleep with wrong LEDs")

endmodule

FILE: dv/dtrc_tb_pkg.sv
// ----------------------------------------------------------------------------
// Relay controller testbench: expected-output tracker
// Tick-by-tick model of the phase, tick counter, on/off state and lamp bits,
// fed one switch sample per accepted transaction, with a queue of outputs
// still owed by the block and the mismatch count.
// ----------------------------------------------------------------------------
package dtrc_tb_pkg;

  class relay_tracker;
    dtrc_pkg::cfg_t                         cfg;
    dtrc_pkg::phase_t                       ph;
    logic [dtrc_pkg::TICK_W-1:0]            ticks;
    logic                                   held_level;
    logic                                   is_on;
    logic [dtrc_pkg::BLINK_W-1:0]           blinks;
    logic                                   drive_relay;
    logic                                   lit_closed;
    logic                                   lit_open;
    dtrc_pkg::result_t                      due_outputs[$];
    int unsigned                            outputs_seen;
    int unsigned                            errors;

    function new();
      cfg.debounce_ticks   = dtrc_pkg::DEBOUNCE_RST;
      cfg.led_gap_ticks    = dtrc_pkg::LED_GAP_RST;
      cfg.lockout_ticks    = dtrc_pkg::LOCKOUT_RST;
      cfg.blink_half_ticks = dtrc_pkg::BLINK_HALF_RST;
      cfg.blink_toggles    = dtrc_pkg::BLINK_TOG_RST;
      ph           = dtrc_pkg::PH_PWR_GAP;
      ticks        = '0;
      held_level   = 1'b1;
      is_on        = 1'b0;
      blinks       = '0;
      drive_relay  = 1'b0;
      lit_closed   = 1'b1;
      lit_open     = 1'b0;
      outputs_seen = 0;
      errors       = 0;
    endfunction

    // Returns the value the register should read back.
    function logic [dtrc_pkg::APB_DW-1:0] set_reg(dtrc_pkg::reg_idx_t idx,
                                                  logic [dtrc_pkg::APB_DW-1:0] val);
      case (idx)
        dtrc_pkg::REG_DEBOUNCE: begin
          cfg.debounce_ticks = val[dtrc_pkg::TICK_W-1:0];
          return dtrc_pkg::APB_DW'(cfg.debounce_ticks);
        end
        dtrc_pkg::REG_LED_GAP: begin
          cfg.led_gap_ticks = val[dtrc_pkg::TICK_W-1:0];
          return dtrc_pkg::APB_DW'(cfg.led_gap_ticks);
        end
        dtrc_pkg::REG_LOCKOUT: begin
          cfg.lockout_ticks = val[dtrc_pkg::TICK_W-1:0];
          return dtrc_pkg::APB_DW'(cfg.lockout_ticks);
        end
        dtrc_pkg::REG_BLINK_HALF: begin
          cfg.blink_half_ticks = val[dtrc_pkg::TICK_W-1:0];
          return dtrc_pkg::APB_DW'(cfg.blink_half_ticks);
        end
        default: begin
          cfg.blink_toggles = val[dtrc_pkg::BLINK_W-1:0];
          return dtrc_pkg::APB_DW'(cfg.blink_toggles);
        end
      endcase
    endfunction

    // saturating tick counter
    function void bump();
      if (ticks != '1) ticks = ticks + 1'b1;
    endfunction

    // a zero period still lasts one tick
    function bit period_over(logic [dtrc_pkg::TICK_W-1:0] limit);
      bump();
      return ticks >= ((limit == '0) ? dtrc_pkg::TICK_W'(1) : limit);
    endfunction

    function bit release_over(logic lvl);
      if (lvl) bump();
      else ticks = '0;
      return ticks >= cfg.debounce_ticks;
    endfunction

    function void note_switch(logic lvl);
      case (ph)
        dtrc_pkg::PH_PWR_GAP: begin
          if (period_over(cfg.led_gap_ticks)) begin
            lit_open = 1'b0;
            ticks    = '0;
            ph       = dtrc_pkg::PH_PWR_RELEASE;
          end
        end
        dtrc_pkg::PH_PWR_RELEASE: begin
          if (release_over(lvl)) begin
            ticks  = '0;
            blinks = '0;
            ph     = (cfg.blink_toggles == '0) ? dtrc_pkg::PH_RELEASE : dtrc_pkg::PH_BLINK;
          end
        end
        dtrc_pkg::PH_BLINK: begin
          if (period_over(cfg.blink_half_ticks)) begin
            lit_closed = ~lit_closed;
            lit_open   = ~lit_open;
            blinks     = blinks + 1'b1;
            ticks      = '0;
            if (blinks >= cfg.blink_toggles) ph = dtrc_pkg::PH_RELEASE;
          end
        end
        dtrc_pkg::PH_RELEASE: begin
          if (release_over(lvl)) begin
            ticks = '0;
            ph    = dtrc_pkg::PH_SLEEP;
          end
        end
        dtrc_pkg::PH_SLEEP: begin
          // the waking sample starts the check with a zero count
          if (lvl == 1'b0) begin
            held_level = 1'b0;
            ticks      = '0;
            ph         = dtrc_pkg::PH_CHECK;
          end
        end
        dtrc_pkg::PH_CHECK: begin
          if (lvl == held_level) begin
            bump();
          end else begin
            held_level = lvl;
            ticks      = '0;
          end
          if (ticks >= cfg.debounce_ticks) begin
            ticks = '0;
            if (held_level == 1'b0) begin
              is_on = ~is_on;
              if (is_on) begin
                drive_relay = 1'b1;
                lit_open    = 1'b1;
              end else begin
                drive_relay = 1'b0;
                lit_closed  = 1'b1;
              end
              ph = dtrc_pkg::PH_GAP;
            end else begin
              ph = dtrc_pkg::PH_RELEASE;
            end
          end
        end
        dtrc_pkg::PH_GAP: begin
          if (period_over(cfg.led_gap_ticks)) begin
            if (is_on) lit_closed = 1'b0;
            else lit_open = 1'b0;
            ticks = '0;
            ph    = dtrc_pkg::PH_LOCKOUT;
          end
        end
        default: begin
          // lockout: switch ignored
          if (period_over(cfg.lockout_ticks)) begin
            ticks = '0;
            ph    = dtrc_pkg::PH_RELEASE;
          end
        end
      endcase
      due_outputs.push_back('{relay_on: drive_relay, led_closed: lit_closed,
                              led_open: lit_open,
                              sleeping: (ph == dtrc_pkg::PH_SLEEP)});
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task check_outputs(dtrc_pkg::result_t got);
      dtrc_pkg::result_t want;
      if (due_outputs.size() == 0) begin
        report_mismatch($sformatf("output %0d arrived with none pending: %b",
                                  outputs_seen, got));
        outputs_seen++;
        return;
      end
      want = due_outputs.pop_front();
      if (got.relay_on !== want.relay_on)
        report_mismatch($sformatf("output %0d relay_on %b, want %b",
                                  outputs_seen, got.relay_on, want.relay_on));
      if (got.led_closed !== want.led_closed)
        report_mismatch($sformatf("output %0d led_closed %b, want %b",
                                  outputs_seen, got.led_closed, want.led_closed));
      if (got.led_open !== want.led_open)
        report_mismatch($sformatf("output %0d led_open %b, want %b",
                                  outputs_seen, got.led_open, want.led_open));
      if (got.sleeping !== want.sleeping)
        report_mismatch($sformatf("output %0d sleeping %b, want %b",
                                  outputs_seen, got.sleeping, want.sleeping));
      outputs_seen++;
    endtask
  endclass

endpackage

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Relay controller testbench
// Drives switch samples through the valid/ready input, programs the timing
// registers over APB between runs (with read-back), and checks every output
// transaction against the tick model. A short directed walk through wake,
// bounce, toggle, gap and lockout comes first, then random press/release
// runs with bounces under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic                          switch_level = 1'b1;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic                          relay_on;
  logic                          led_closed;
  logic                          led_open;
  logic                          sleeping;
  logic                          psel         = 1'b0;
  logic                          penable      = 1'b0;
  logic                          pwrite       = 1'b0;
  logic [dtrc_pkg::APB_AW-1:0]   paddr        = '0;
  logic [dtrc_pkg::APB_DW-1:0]   pwdata       = '0;
  logic [dtrc_pkg::APB_DW-1:0]   prdata;
  logic                          pready;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  // wake, bounce back to release, wake, toggle on, gap, lockout, release
  localparam logic [23:0] WALK = 24'b010111111001111100000011;

  // debounce, gap, lockout, blink half period, blink toggles per run
  int unsigned plan_deb  [8] = '{1, 0, 3, 65535, 2, 4, 1, 2};
  int unsigned plan_gap  [8] = '{0, 1, 2, 65535, 4, 3, 0, 1};
  int unsigned plan_lock [8] = '{0, 2, 5, 65535, 1, 7, 0, 3};
  int unsigned plan_half [8] = '{1, 0, 2, 65535, 1, 3, 1, 1};
  int unsigned plan_tog  [8] = '{0, 31, 3, 31, 4, 2, 1, 5};

  dtrc_tb_pkg::relay_tracker tracker = new();

  debounced_toggle_relay_controller #(
    .COUNT_WIDTH(dtrc_pkg::TICK_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .switch_level (switch_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .relay_on     (relay_on),
    .led_closed   (led_closed),
    .led_open     (led_open),
    .sleeping     (sleeping),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_switch(switch_level);
      if (out_valid && out_ready)
        tracker.check_outputs({relay_on, led_closed, led_open, sleeping});
    end
  end

  task automatic set_idle(input int unsigned mode);
    case (mode)
      0: begin
        send_gap_pct   = 11;
        recv_stall_pct = 81;
      end
      1: begin
        send_gap_pct   = 81;
        recv_stall_pct = 11;
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // call at a falling edge; returns at a falling edge
  task automatic send_level(input logic lvl);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    switch_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.due_outputs.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_reg(input dtrc_pkg::reg_idx_t idx, input int unsigned val);
    logic [dtrc_pkg::APB_DW-1:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= dtrc_pkg::APB_DW'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    stored = tracker.set_reg(idx, dtrc_pkg::APB_DW'(val));
    @(negedge clk);
    // read back the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== stored)
      tracker.report_mismatch($sformatf("register %s read %h, want %h",
                                        idx.name(), prdata, stored));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_all(input int unsigned deb, input int unsigned gap,
                             input int unsigned lock, input int unsigned half,
                             input int unsigned tog);
    drain();
    program_reg(dtrc_pkg::REG_DEBOUNCE, deb);
    program_reg(dtrc_pkg::REG_LED_GAP, gap);
    program_reg(dtrc_pkg::REG_LOCKOUT, lock);
    program_reg(dtrc_pkg::REG_BLINK_HALF, half);
    program_reg(dtrc_pkg::REG_BLINK_TOG, tog);
  endtask

  // mostly clean press/release runs sized around the debounce window,
  // mixed with bounce bursts and lone glitches
  task automatic run_random(input int unsigned count, input int unsigned deb);
    int unsigned sent;
    int unsigned span;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    span = (deb > 16) ? 16 : ((deb == 0) ? 1 : deb);
    while (sent < count) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        len = $urandom_range(2 * span + 4, span / 2 + 1);
        repeat (len) send_level(1'b0);
        sent += len;
        len = $urandom_range(3 * span + 10, 1);
        repeat (len) send_level(1'b1);
        sent += len;
      end else if (pick < 9) begin
        len = $urandom_range(6, 1);
        repeat (len) send_level(1'($urandom_range(1)));
        sent += len;
      end else begin
        send_level(1'b0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // odd blink count, short windows: walk every phase by hand
    set_idle(0);
    program_all(2, 0, 0, 1, 1);
    for (int i = 23; i >= 0; i--) send_level(WALK[i]);

    for (int p = 0; p < 8; p++) begin
      set_idle(p / 3);
      program_all(plan_deb[p], plan_gap[p], plan_lock[p], plan_half[p], plan_tog[p]);
      run_random(228, plan_deb[p]);
    end

    drain();
    repeat (10) @(negedge clk);
    if (tracker.due_outputs.size() != 0)
      tracker.report_mismatch($sformatf("%0d expected outputs never arrived",
                                        tracker.due_outputs.size()));
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
